// ===== sv/mts_pkg.sv =====
// ---------------------------------------------------------------------------
// Melody tone sequencer package
// Shared types, operation codes, register indexes and fixed widths.
// ---------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  // Fixed field widths.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned IDXF_W    = 6;
  localparam int unsigned PITCH_W   = 13;
  localparam int unsigned DIVIDER_W = 8;
  localparam int unsigned WHOLE_W   = 16;
  localparam int unsigned MLEN_W    = 7;
  localparam int unsigned TIME_W    = 17;
  // Width of the note length scaled by ten or nine.
  localparam int unsigned SCALED_W  = TIME_W + 4;
  localparam int unsigned ENTRY_W   = PITCH_W + DIVIDER_W;

  // Input and output word widths.
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Divider: one quotient bit per step.
  localparam int unsigned DIV_STEPS = WHOLE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Reset values of the configuration registers.
  localparam logic [WHOLE_W-1:0] WHOLE_RESET = 16'd2285;
  localparam logic [MLEN_W-1:0]  MLEN_RESET  = 7'd32;

  // Saturation limit of the elapsed counter.
  localparam logic [TIME_W-1:0] ELAPSED_MAX = {TIME_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHOLE_NOTE = 1'b0,
    REG_MELODY_LEN = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PITCH_RD,
    ST_OUT
  } state_t;

  // Status of the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== sv/mts_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/mts_divider.sv =====
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring division of the whole note length by the divider magnitude,
// one quotient bit per clock.
// ---------------------------------------------------------------------------
`default_nettype none

module mts_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [mts_pkg::WHOLE_W-1:0]   dividend,
  input  wire logic [mts_pkg::DIVIDER_W-1:0] divisor,
  output logic      [mts_pkg::WHOLE_W-1:0]   quotient,
  output mts_pkg::div_stat_t                 stat
);

  import mts_pkg::*;

  logic [WHOLE_W-1:0]   quo_r, quo_nxt;
  logic [DIVIDER_W-1:0] rem_r, rem_nxt;
  logic [DIVIDER_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIVIDER_W:0]   trial;

  // One restoring step: shift the next dividend bit into the remainder.
  always_comb begin
    trial    = {rem_r, quo_r[WHOLE_W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIVIDER_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[WHOLE_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVIDER_W-1:0];
        quo_nxt = {quo_r[WHOLE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Step registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ===== sv/melody_tone_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// Melody tone sequencer
// Plays a looping table of (pitch, divider) entries on millisecond ticks,
// with a silent gap in the last tenth of every note.
// ---------------------------------------------------------------------------
//   Channel  Direction  Word contents
//   in_      slave      tuser: operation; tdata: entry_index, entry_pitch,
//                       entry_divider
//   out_     master     tdata: tone_on, tone_pitch, note_index, playing,
//                       note_started (one word per input word)
//   cfg_     slave      cfg_index selects whole_note_ms (0) or melody_length (1)
//
// A word that does not change notes passes through the pitch read state before
// it loads the output register. A word that starts a note with a nonzero divider
// goes through the table read, the divider load, 16 divider steps, the length
// latch and the output load; with a zero divider it skips the divider steps.
// The input is ready again as soon as the output register loads. Reset is
// synchronous, active low, and needs no clearing pass. The input stays not
// ready until the result is placed in the output register, which holds it
// while out_tready is low.
// ---------------------------------------------------------------------------
`default_nettype none

module melody_tone_sequencer_top #(
  parameter int unsigned MAX_NOTES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input words.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [5:0] entry_index, [18:6] entry_pitch, [26:19] entry_divider
  input  wire logic [mts_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] operation
  input  wire logic [mts_pkg::OP_W-1:0]          in_tuser,
  // Result words.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [0] tone_on, [13:1] tone_pitch, [19:14] note_index, [20] playing,
  // [21] note_started
  output logic      [mts_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration writes.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mts_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import mts_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_NOTES);
  localparam int unsigned NX_W  = IDX_W + 1;
  localparam int unsigned CMP_W = (NX_W > MLEN_W) ? ((NX_W > IDXF_W) ? NX_W : IDXF_W)
                                                  : ((MLEN_W > IDXF_W) ? MLEN_W : IDXF_W);
  localparam logic [CMP_W-1:0] NOTES_LIMIT = CMP_W'(MAX_NOTES);

  // Input fields.
  op_t                  in_op;
  logic [IDXF_W-1:0]    in_index;
  logic [PITCH_W-1:0]   in_pitch;
  logic [DIVIDER_W-1:0] in_divider;
  logic                 in_acc;

  assign in_op      = op_t'(in_tuser);
  assign in_index   = in_tdata[IDXF_W-1:0];
  assign in_pitch   = in_tdata[IDXF_W+PITCH_W-1:IDXF_W];
  assign in_divider = in_tdata[IDXF_W+PITCH_W+DIVIDER_W-1:IDXF_W+PITCH_W];
  assign in_acc     = in_tvalid && in_tready;

  // Registers.
  state_t               state_r, state_nxt;
  logic [WHOLE_W-1:0]   whole_r, whole_nxt;
  logic [MLEN_W-1:0]    mlen_r, mlen_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [TIME_W-1:0]    elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0]    len_r, len_nxt;
  logic                 active_r, active_nxt;
  logic                 gap_r, gap_nxt;
  logic                 started_r, started_nxt;
  logic                 dotted_r, dotted_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Table memory and divider.
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [PITCH_W-1:0]   rd_pitch;
  logic [DIVIDER_W-1:0] rd_divider;
  logic                 div_start;
  logic [DIVIDER_W-1:0] div_mag;
  logic [WHOLE_W-1:0]   div_quo;
  div_stat_t            div_stat;
  logic [TIME_W-1:0]    new_len;

  // Tick arithmetic.
  logic [TIME_W-1:0]    tick_elapsed;
  logic [SCALED_W-1:0]  elapsed_x10;
  logic [SCALED_W-1:0]  len_x9;
  logic                 tick_gap;
  logic [NX_W-1:0]      next_idx;
  logic                 wrap;
  logic                 out_load;

  assign ram_we    = in_acc && (in_op == OP_WRITE) && (CMP_W'(in_index) < NOTES_LIMIT);
  assign ram_waddr = IDX_W'(in_index);

  mts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NOTES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data ({in_divider, in_pitch}),
    .rd_addr (cur_r),
    .rd_data (ram_rdata)
  );

  assign rd_pitch   = ram_rdata[PITCH_W-1:0];
  assign rd_divider = ram_rdata[ENTRY_W-1:PITCH_W];
  assign div_mag    = rd_divider[DIVIDER_W-1] ? DIVIDER_W'(-rd_divider) : rd_divider;
  assign div_start  = (state_r == ST_DIV_GO) && (rd_divider != '0);

  mts_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (whole_r),
    .divisor  (div_mag),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Dotted notes add half of the quotient.
  assign new_len = dotted_r ? (TIME_W'(div_quo) + TIME_W'(div_quo[WHOLE_W-1:1]))
                            : TIME_W'(div_quo);

  // Elapsed count after a tick and the ninety-percent gap test.
  assign tick_elapsed = (elapsed_r != ELAPSED_MAX) ? elapsed_r + 1'b1 : elapsed_r;
  assign elapsed_x10  = (SCALED_W'(tick_elapsed) << 3) + (SCALED_W'(tick_elapsed) << 1);
  assign len_x9       = (SCALED_W'(len_r) << 3) + SCALED_W'(len_r);
  assign tick_gap     = gap_r || (elapsed_x10 >= len_x9);
  assign next_idx     = NX_W'(cur_r) + 1'b1;
  assign wrap         = (CMP_W'(next_idx) >= CMP_W'(mlen_r)) ||
                        (CMP_W'(next_idx) >= NOTES_LIMIT);

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_op == OP_START) begin
            state_nxt = ST_LOAD_RD;
          end else if (in_op == OP_TICK && active_r && tick_gap &&
                       tick_elapsed >= len_r) begin
            state_nxt = ST_LOAD_RD;
          end else begin
            state_nxt = ST_PITCH_RD;
          end
        end
      end
      ST_LOAD_RD: begin
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = (rd_divider != '0) ? ST_DIV_WAIT : ST_PITCH_RD;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_PITCH_RD;
        end
      end
      ST_PITCH_RD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and handshake outputs.
  always_comb begin
    whole_nxt     = whole_r;
    mlen_nxt      = mlen_r;
    cur_nxt       = cur_r;
    elapsed_nxt   = elapsed_r;
    len_nxt       = len_r;
    active_nxt    = active_r;
    gap_nxt       = gap_r;
    started_nxt   = started_r;
    dotted_nxt    = dotted_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_tready     = (state_r == ST_IDLE);
    cfg_ready     = 1'b1;

    // Configuration register writes.
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WHOLE_NOTE: whole_nxt = cfg_data;
        REG_MELODY_LEN: mlen_nxt  = cfg_data[MLEN_W-1:0];
        default: begin
        end
      endcase
    end

    // Operation decode on an accepted word.
    if (in_acc) begin
      started_nxt = 1'b0;
      unique case (in_op)
        OP_TICK: begin
          if (active_r) begin
            elapsed_nxt = tick_elapsed;
            gap_nxt     = tick_gap;
            if (tick_gap && tick_elapsed >= len_r) begin
              cur_nxt     = wrap ? '0 : IDX_W'(next_idx);
              elapsed_nxt = '0;
              started_nxt = 1'b1;
            end
          end
        end
        OP_START: begin
          active_nxt  = 1'b1;
          cur_nxt     = '0;
          elapsed_nxt = '0;
          started_nxt = 1'b1;
        end
        OP_STOP: begin
          active_nxt = 1'b0;
        end
        OP_WRITE: begin
        end
        default: begin
        end
      endcase
    end

    // New note: zero divider keeps the old length.
    if (state_r == ST_DIV_GO) begin
      dotted_nxt = rd_divider[DIVIDER_W-1];
      if (rd_divider == '0) begin
        gap_nxt = (len_r == '0);
      end
    end
    if (state_r == ST_DIV_WAIT && div_stat.done) begin
      len_nxt = new_len;
      gap_nxt = (new_len == '0);
    end

    // Output register.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_DATA_W'({started_r, active_r, IDXF_W'(cur_r),
                                   active_r ? rd_pitch : {PITCH_W{1'b0}},
                                   active_r && !gap_r});
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      whole_r     <= WHOLE_RESET;
      mlen_r      <= MLEN_RESET;
      cur_r       <= '0;
      elapsed_r   <= '0;
      len_r       <= '0;
      active_r    <= 1'b0;
      gap_r       <= 1'b0;
      started_r   <= 1'b0;
      dotted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      whole_r     <= whole_nxt;
      mlen_r      <= mlen_nxt;
      cur_r       <= cur_nxt;
      elapsed_r   <= elapsed_nxt;
      len_r       <= len_nxt;
      active_r    <= active_nxt;
      gap_r       <= gap_nxt;
      started_r   <= started_nxt;
      dotted_r    <= dotted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
